// File: rtl/dnce_pkg.sv
package dnce_pkg;

    // Buffer geometry and label limit.
    localparam int WIRE_CAPACITY = 256;
    localparam int MAX_LABEL_LEN = 63;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 6;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_END     = 8'd0;
    localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'd46;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]  t_len;

    // One buffer write or name-end report.
    typedef struct packed {
        t_byte write_addr;
        t_byte write_byte;
        logic  name_done;
        logic  encode_error;
        t_pos  wire_length;
    } t_res;

    // One queue entry: one result, or two when pair is set.
    typedef struct packed {
        logic pair;
        t_res first;
        t_res second;
    } t_cmd;

    // Lower-case the letters A to Z and pass every other byte through.
    function automatic t_byte to_lower(t_byte c);
        t_byte r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: rtl/dnce_if.sv
// Character channel: one dotted-name character per transfer.
interface dnce_char_if;
    logic               valid;
    logic               ready;
    dnce_pkg::t_byte    name_char;

    modport source (output valid, output name_char, input ready);
    modport sink   (input valid, input name_char, output ready);
endinterface

// Result channel: one buffer write or name-end report per transfer.
interface dnce_res_if;
    logic               valid;
    logic               ready;
    dnce_pkg::t_byte    write_addr;
    dnce_pkg::t_byte    write_byte;
    logic               name_done;
    logic               encode_error;
    dnce_pkg::t_pos     wire_length;

    modport source (output valid, output write_addr, output write_byte,
                    output name_done, output encode_error, output wire_length,
                    input ready);
    modport sink   (input valid, input write_addr, input write_byte,
                    input name_done, input encode_error, input wire_length,
                    output ready);
endinterface

// File: rtl/dnce_front.sv
module dnce_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dnce_char_if.sink       i_char,
    input  logic            i_full,
    output logic            o_push,
    output dnce_pkg::t_cmd  o_cmd
);
    import dnce_pkg::*;

    t_pos  r_write_pos,   n_write_pos;
    t_byte r_label_start, n_label_start;
    t_len  r_label_len,   n_label_len;
    logic  r_label_open,  n_label_open;
    logic  r_error_seen,  n_error_seen;

    logic  w_accept;

    function automatic t_res mk_write(t_byte addr, t_byte data);
        t_res r;
        r = '0;
        r.write_addr = addr;
        r.write_byte = data;
        return r;
    endfunction

    // A character is taken whenever the queue has room.
    assign i_char.ready = !i_full;
    assign w_accept     = i_char.valid && !i_full;

    // Classify the character, update the name state and build the command.
    always_comb begin
        t_pos  v_pos;
        t_len  v_len;
        logic  v_err;
        t_res  v_final;

        n_write_pos   = r_write_pos;
        n_label_start = r_label_start;
        n_label_len   = r_label_len;
        n_label_open  = r_label_open;
        n_error_seen  = r_error_seen;
        o_push        = 1'b0;
        o_cmd         = '0;
        v_pos         = r_write_pos;
        v_len         = r_label_len;
        v_err         = 1'b0;
        v_final       = '0;

        if (w_accept) begin
            if (i_char.name_char == CHAR_END) begin
                // End of name: close an open label, then the terminating zero or the error report.
                v_err = r_error_seen || r_write_pos >= POS_W'(WIRE_CAPACITY)
                        || r_write_pos[POS_W-1];
                v_final.name_done = 1'b1;
                if (v_err) begin
                    v_final.encode_error = 1'b1;
                end else begin
                    v_final.write_addr  = r_write_pos[BYTE_W-1:0];
                    v_final.wire_length = r_write_pos + POS_W'(1);
                end
                o_push = 1'b1;
                if (!r_error_seen && r_label_open) begin
                    o_cmd.pair   = 1'b1;
                    o_cmd.first  = mk_write(r_label_start, BYTE_W'(r_label_len));
                    o_cmd.second = v_final;
                end else begin
                    o_cmd.first  = v_final;
                end
                n_write_pos   = '0;
                n_label_start = '0;
                n_label_len   = '0;
                n_label_open  = 1'b0;
                n_error_seen  = 1'b0;
            end else if (!r_error_seen) begin
                if (i_char.name_char == CHAR_DOT) begin
                    // Dot: close the open label, or encode an empty one.
                    if (r_label_open) begin
                        o_push       = 1'b1;
                        o_cmd.first  = mk_write(r_label_start, BYTE_W'(r_label_len));
                        n_label_open = 1'b0;
                    end else if (r_write_pos >= POS_W'(WIRE_CAPACITY)) begin
                        n_error_seen = 1'b1;
                    end else begin
                        o_push        = 1'b1;
                        o_cmd.first   = mk_write(r_write_pos[BYTE_W-1:0], '0);
                        n_label_start = r_write_pos[BYTE_W-1:0];
                        n_write_pos   = r_write_pos + POS_W'(1);
                        n_label_len   = '0;
                    end
                end else begin
                    // Label character: reserve the length byte first if needed.
                    if (!r_label_open) begin
                        if (r_write_pos >= POS_W'(WIRE_CAPACITY)) begin
                            v_err = 1'b1;
                        end else begin
                            n_label_start = r_write_pos[BYTE_W-1:0];
                            n_label_open  = 1'b1;
                            v_pos         = r_write_pos + POS_W'(1);
                            v_len         = '0;
                        end
                    end
                    n_write_pos = v_pos;
                    n_label_len = v_len;
                    if (v_err || v_pos >= POS_W'(WIRE_CAPACITY)
                        || v_len >= LEN_W'(MAX_LABEL_LEN)) begin
                        n_error_seen = 1'b1;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.first = mk_write(v_pos[BYTE_W-1:0],
                                               to_lower(i_char.name_char));
                        n_write_pos = v_pos + POS_W'(1);
                        n_label_len = v_len + LEN_W'(1);
                    end
                end
            end
        end
    end

    // Name state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos   <= '0;
            r_label_start <= '0;
            r_label_len   <= '0;
            r_label_open  <= 1'b0;
            r_error_seen  <= 1'b0;
        end else begin
            r_write_pos   <= n_write_pos;
            r_label_start <= n_label_start;
            r_label_len   <= n_label_len;
            r_label_open  <= n_label_open;
            r_error_seen  <= n_error_seen;
        end
    end

    // The end of a name always leaves the state cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_char.name_char == CHAR_END |=>
        r_write_pos == '0 && !r_label_open && !r_error_seen)
        else $error("name state not cleared after name end");

    // The write position never runs past the buffer.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pos <= POS_W'(WIRE_CAPACITY))
        else $error("write position beyond capacity");

endmodule

// File: rtl/dnce_queue.sv
module dnce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dnce_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output dnce_pkg::t_cmd  o_head
);
    import dnce_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + QUEUE_AW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + QUEUE_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Neither a push into a full queue nor a pop from an empty one.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue overrun or underrun");

endmodule

// File: rtl/dnce_back.sv
module dnce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  dnce_pkg::t_cmd  i_head,
    output logic            o_pop,
    dnce_res_if.source      o_res
);
    import dnce_pkg::*;

    t_cmd r_cmd;
    logic r_valid;
    logic r_half;
    logic w_take;
    logic w_last;
    t_res w_cur;

    // The current result is the first or second half of the held command.
    assign w_cur  = r_half ? r_cmd.second : r_cmd.first;
    assign w_last = !r_cmd.pair || r_half;
    assign w_take = r_valid && o_res.ready;
    assign o_pop  = !i_empty && (!r_valid || (w_take && w_last));

    assign o_res.valid        = r_valid;
    assign o_res.write_addr   = w_cur.write_addr;
    assign o_res.write_byte   = w_cur.write_byte;
    assign o_res.name_done    = w_cur.name_done;
    assign o_res.encode_error = w_cur.encode_error;
    assign o_res.wire_length  = w_cur.wire_length;

    // Output stage control: load a new command, step to its second half or drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_half  <= 1'b0;
        end else if (w_take && !w_last) begin
            r_half  <= 1'b1;
        end else if (w_take) begin
            r_valid <= 1'b0;
        end
    end

    // Held command payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    // A second half is only shown for a two-result command.
    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_half |-> r_cmd.pair)
        else $error("second half shown for single-result command");

endmodule

// File: rtl/dns_name_canonical_encoder.sv
// DNS name encoder to canonical wire format. Send the dotted name one byte per
// transfer on i_char and end it with a zero byte; o_res returns buffer writes
// (address and byte) with letters lower-cased, each label's length byte written
// at its reserved address when the label closes, and a final terminating-zero
// write that carries name_done and wire_length. A label over 63 bytes or a name
// that does not fit in 256 bytes yields a final result with encode_error and
// name_done set at the end of the name. One character is accepted per cycle
// while the command queue after the classifying front has room; each result is
// registered in that queue, then in the output stage. The output stage sends
// one result per cycle while o_res.ready is high, so a name end that closes an
// open label yields two results; the four-entry queue absorbs this and output stalls.
module dns_name_canonical_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnce_char_if.sink   i_char,
    dnce_res_if.source  o_res
);
    import dnce_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    dnce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    dnce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    dnce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

// File: dv/dnce_wire_check.sv
`timescale 1ns / 1ps

// Watches both channels, encodes each accepted character on its own copy
// of the encoder state and compares every result transfer in order.
module dnce_wire_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnce_char_if       i_char,
    dnce_res_if        i_res,
    output int         o_fail_count,
    output int         o_pending
);
    import dnce_pkg::*;

    // Writes still owed by the block, oldest first.
    t_res wire_q[$];
    int   fails = 0;

    // Encoder state for the name in progress.
    t_pos   pos;
    t_byte  lbl_start;
    t_len   lbl_len;
    logic   lbl_open;
    logic   name_failed;

    function automatic void clear_name_state();
        pos         = '0;
        lbl_start   = '0;
        lbl_len     = '0;
        lbl_open    = 1'b0;
        name_failed = 1'b0;
    endfunction

    function automatic void queue_write(t_byte addr, t_byte data, logic done, logic err,
                                        t_pos total);
        t_res r;
        r.write_addr   = addr;
        r.write_byte   = data;
        r.name_done    = done;
        r.encode_error = err;
        r.wire_length  = total;
        wire_q.push_back(r);
    endfunction

    // Reserve one address for a label length; a full buffer fails the name.
    function automatic logic reserve_length_byte();
        if (pos >= WIRE_CAPACITY) begin
            name_failed = 1'b1;
            return 1'b0;
        end
        lbl_start = pos[BYTE_W-1:0];
        pos       = pos + 1'b1;
        lbl_len   = '0;
        return 1'b1;
    endfunction

    // Work out the writes that one character causes.
    function automatic void encode_char(t_byte c);
        t_byte low;
        if (c == CHAR_END) begin
            // Close an open label, then append the terminating zero.
            if (!name_failed && lbl_open) begin
                queue_write(lbl_start, t_byte'(lbl_len), 1'b0, 1'b0, '0);
                lbl_open = 1'b0;
            end
            if (!name_failed && (pos >= WIRE_CAPACITY || pos > 9'd255)) begin
                name_failed = 1'b1;
            end
            if (name_failed) begin
                queue_write('0, '0, 1'b1, 1'b1, '0);
            end else begin
                queue_write(pos[BYTE_W-1:0], '0, 1'b1, 1'b0, pos + 1'b1);
            end
            clear_name_state();
            return;
        end
        // Once a name has failed, everything up to its end is dropped.
        if (name_failed) begin
            return;
        end
        if (c == CHAR_DOT) begin
            // A dot closes the open label, or encodes an empty one.
            if (lbl_open) begin
                queue_write(lbl_start, t_byte'(lbl_len), 1'b0, 1'b0, '0);
                lbl_open = 1'b0;
            end else if (reserve_length_byte()) begin
                queue_write(lbl_start, '0, 1'b0, 1'b0, '0);
            end
            return;
        end
        if (!lbl_open) begin
            if (!reserve_length_byte()) begin
                return;
            end
            lbl_open = 1'b1;
        end
        if (pos >= WIRE_CAPACITY || lbl_len >= MAX_LABEL_LEN) begin
            name_failed = 1'b1;
            return;
        end
        low = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
        queue_write(pos[BYTE_W-1:0], low, 1'b0, 1'b0, '0);
        pos     = pos + 1'b1;
        lbl_len = lbl_len + 1'b1;
    endfunction

    // Compare one result transfer with the oldest owed write.
    function automatic void check_write(t_res got);
        t_res want;
        if (wire_q.size() == 0) begin
            $display("%0t: unexpected write addr %0d byte %0d done %0b err %0b len %0d",
                     $time, got.write_addr, got.write_byte, got.name_done,
                     got.encode_error, got.wire_length);
            fails++;
            return;
        end
        want = wire_q.pop_front();
        if (got.write_addr !== want.write_addr) begin
            $display("%0t: write_addr expected %0d, got %0d",
                     $time, want.write_addr, got.write_addr);
            fails++;
        end
        if (got.write_byte !== want.write_byte) begin
            $display("%0t: write_byte expected %0d, got %0d",
                     $time, want.write_byte, got.write_byte);
            fails++;
        end
        if (got.name_done !== want.name_done) begin
            $display("%0t: name_done expected %0b, got %0b",
                     $time, want.name_done, got.name_done);
            fails++;
        end
        if (got.encode_error !== want.encode_error) begin
            $display("%0t: encode_error expected %0b, got %0b",
                     $time, want.encode_error, got.encode_error);
            fails++;
        end
        if (got.wire_length !== want.wire_length) begin
            $display("%0t: wire_length expected %0d, got %0d",
                     $time, want.wire_length, got.wire_length);
            fails++;
        end
    endfunction

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        t_res got;
        if (!i_rst_n) begin
            clear_name_state();
            wire_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.write_addr   = i_res.write_addr;
                got.write_byte   = i_res.write_byte;
                got.name_done    = i_res.name_done;
                got.encode_error = i_res.encode_error;
                got.wire_length  = i_res.wire_length;
                check_write(got);
            end
            if (i_char.valid && i_char.ready) begin
                encode_char(i_char.name_char);
            end
        end
        o_pending    <= wire_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dnce_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 7;
    localparam int RUN_LIMIT_CYCLES = 100000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int PHASE_ITEMS      = 30;
    localparam int HOLD_CYCLES      = 150;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    pending;
    int    src_idle_pct;
    int    sink_idle_pct;
    int    hold_cycles;
    int    items_sent;
    t_byte name_q[$];

    dnce_char_if char_bus();
    dnce_res_if  res_bus();

    dns_name_canonical_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus)
    );

    dnce_wire_check u_wire_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (char_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one character and wait for its transfer; called at a falling edge.
    task automatic put_char(input t_byte c);
        while ($urandom_range(99) < src_idle_pct) begin
            char_bus.valid     <= 1'b0;
            char_bus.name_char <= t_byte'($urandom);
            @(negedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.name_char <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_quiet();
        char_bus.valid     <= 1'b0;
        char_bus.name_char <= t_byte'($urandom);
    endtask

    task automatic send_name();
        foreach (name_q[i]) put_char(name_q[i]);
        put_char(CHAR_END);
        name_q.delete();
    endtask

    // Mostly letters of both cases, otherwise any byte that is not a code.
    function automatic t_byte label_char();
        t_byte c;
        if ($urandom_range(1) == 1) begin
            c = t_byte'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
            if ($urandom_range(1) == 1) begin
                c = c + CASE_OFFSET;
            end
        end else begin
            c = t_byte'($urandom_range(1, 255));
            if (c == CHAR_DOT) begin
                c = CHAR_DOT + 1'b1;
            end
        end
        return c;
    endfunction

    function automatic void add_label(int n);
        for (int i = 0; i < n; i++) name_q.push_back(label_char());
    endfunction

    function automatic void add_dot();
        name_q.push_back(CHAR_DOT);
    endfunction

    // Names near the buffer capacity: three full labels, then a tail that
    // lands exactly on the limit or runs past it at different points.
    task automatic send_big_name(input int variant);
        for (int i = 0; i < 3; i++) begin
            if (i > 0) add_dot();
            add_label(MAX_LABEL_LEN);
        end
        case (variant)
            0: begin
                add_dot();
                add_label(MAX_LABEL_LEN - 1);
            end
            1: begin
                add_dot();
                add_label(MAX_LABEL_LEN);
                if ($urandom_range(1) == 1) add_dot();
            end
            2: begin
                add_dot();
                add_label(MAX_LABEL_LEN);
                add_dot();
                add_label($urandom_range(1, 4));
            end
            default: begin
                add_dot();
                add_dot();
                add_label(MAX_LABEL_LEN);
                add_label($urandom_range(0, 3));
            end
        endcase
        send_name();
    endtask

    task automatic send_random_name();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 10) begin
            // Raw noise, dots included.
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
                name_q.push_back(($urandom_range(3) == 0) ? CHAR_DOT
                                                          : t_byte'($urandom_range(1, 255)));
            end
        end else if (kind < 22) begin
            // A label around the length limit, with labels around it.
            if ($urandom_range(1) == 1) begin
                add_label($urandom_range(1, 5));
                add_dot();
            end
            add_label($urandom_range(MAX_LABEL_LEN - 3, MAX_LABEL_LEN + 3));
            if ($urandom_range(1) == 1) begin
                add_dot();
                add_label($urandom_range(1, 4));
            end
        end else if (kind < 34) begin
            // Leading, doubled and trailing dots between short labels.
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1) == 1) add_dot();
                else add_label($urandom_range(1, 3));
            end
        end else begin
            // Ordinary well-formed name, sometimes with a trailing dot.
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0) add_dot();
                add_label($urandom_range(1, 10));
            end
            if ($urandom_range(4) == 0) add_dot();
        end
        send_name();
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) send_random_name();
    endtask

    // Stop offering and wait until every owed write has come back.
    task automatic wait_drained();
        go_quiet();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        go_quiet();
        @(posedge i_clk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        @(negedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        go_quiet();
        @(posedge i_clk);
        hold_cycles = cycles;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.name_char = '0;
        res_bus.ready      = 1'b0;
        src_idle_pct       = 19;
        sink_idle_pct      = 55;
        hold_cycles        = 0;
        items_sent         = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty name.
        send_name();
        // Lone leading dot.
        add_dot();
        send_name();
        // Letter edges, a doubled dot, top and bottom bytes, trailing dot.
        name_q = '{8'h61, 8'h5a, 8'h40, 8'h5b, CHAR_DOT, CHAR_DOT,
                   8'hff, 8'h01, CHAR_DOT};
        send_name();
        // Bytes just outside the letter ranges.
        name_q = '{8'h60, 8'h7b, 8'h80};
        send_name();

        // Sender idles lightly, receiver heavily; a name that fills the buffer.
        send_big_name(0);
        run_random(PHASE_ITEMS);

        // Roles swapped; a name that overruns the buffer at one of its limits.
        set_idling(55, 19);
        send_big_name($urandom_range(1, 3));
        run_random(PHASE_ITEMS);

        // No idling; first a long receiver hold-off that backs up the input.
        set_idling(0, 0);
        hold_receiver(HOLD_CYCLES);
        run_random(PHASE_ITEMS);
        wait_drained();
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
